// ===== rtl/usm_pkg.sv =====
// ----------------------------------------------------------------------------
// usm_pkg
// Shared constants and helper functions for the UV-sphere mesh generator.
// ----------------------------------------------------------------------------
package usm_pkg;

    localparam int PHASE_W    = 16;
    localparam int CORDIC_W   = 34;
    localparam int CORDIC_N   = 16;
    localparam int ITER_W     = $clog2(CORDIC_N);
    localparam int Q15_MAX    = 32767;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_RADIUS    = 2'd0,
        REG_LAT_COUNT = 2'd1,
        REG_LON_COUNT = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    // Arctangent of 2^-i as a fraction of a full turn of 2^32
    function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [CORDIC_W-1:0] v;
        unique case (i)
            4'd0:  v = 34'sd536870912;
            4'd1:  v = 34'sd316933405;
            4'd2:  v = 34'sd167458907;
            4'd3:  v = 34'sd85004756;
            4'd4:  v = 34'sd42667331;
            4'd5:  v = 34'sd21354465;
            4'd6:  v = 34'sd10679838;
            4'd7:  v = 34'sd5340245;
            4'd8:  v = 34'sd2670163;
            4'd9:  v = 34'sd1335086;
            4'd10: v = 34'sd667544;
            4'd11: v = 34'sd333772;
            4'd12: v = 34'sd166886;
            4'd13: v = 34'sd83443;
            4'd14: v = 34'sd41721;
            4'd15: v = 34'sd20860;
        endcase
        return v;
    endfunction

    // Round a Q2.30 value to Q1.15 and clamp to the symmetric range
    function automatic logic signed [15:0] rnd_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            return 16'sd32767;
        end
        if (r < -34'sd32767) begin
            return -16'sd32767;
        end
        return r[15:0];
    endfunction

endpackage

// ===== rtl/usm_div.sv =====
// ----------------------------------------------------------------------------
// usm_div
// Restoring divider giving floor(numer * 2^16 / denom), one bit per cycle.
// ----------------------------------------------------------------------------
module usm_div #(
    parameter int W = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [W-1:0]                 numer,
    input  logic [W-1:0]                 denom,
    output logic                         done,
    output logic [usm_pkg::PHASE_W-1:0]  quot
);
    import usm_pkg::*;

    logic [W-1:0]         rem_reg;
    logic [PHASE_W-1:0]   quot_reg;
    logic [ITER_W-1:0]    cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [W:0]           shifted;
    logic                 ge;
    logic [W:0]           diff;

    // The numerator is below the divisor, so the remainder always fits W bits.
    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, denom};
    assign diff    = shifted - {1'b0, denom};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= numer;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[W-1:0] : shifted[W-1:0];
                quot_reg <= {quot_reg[PHASE_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(PHASE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/usm_cordic.sv =====
// ----------------------------------------------------------------------------
// usm_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving the
// cosine and sine of a 16-bit phase in Q1.15.
// ----------------------------------------------------------------------------
module usm_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [usm_pkg::PHASE_W-1:0]         phase,
    output logic                                done,
    output logic signed [15:0]                  cos_q,
    output logic signed [15:0]                  sin_q
);
    import usm_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic [1:0]                 quad_reg;
    logic [ITER_W-1:0]          i_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] at;
    logic signed [15:0]         xr;
    logic signed [15:0]         yr;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = atan_lut(i_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            quad_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= CORDIC_W'({phase[13:0], 16'h0000});
                quad_reg <= phase[15:14];
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == ITER_W'(CORDIC_N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign xr = rnd_q15(x_reg);
    assign yr = rnd_q15(y_reg);

    // Quadrant fold-out of the first-quadrant result
    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cos_q = xr;
                sin_q = yr;
            end
            2'd1:
            begin
                cos_q = -yr;
                sin_q = xr;
            end
            2'd2:
            begin
                cos_q = -xr;
                sin_q = -yr;
            end
            2'd3:
            begin
                cos_q = yr;
                sin_q = -xr;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== rtl/uv_sphere_mesh_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// Emits one element of a UV-sphere mesh per request transaction.
// ----------------------------------------------------------------------------
// Each transaction on the request channel (in_valid, in_stall, restart) yields
// exactly one result transaction on the output channel (out_valid, out_stall):
// the pole and ring vertices first, then the triangle indices, with last set
// on the final triangle, after which the mesh starts again at the top pole.
// restart = 1 makes the transaction return the top pole vertex.
// Poles and triangles go from acceptance through the C_OUT state into the
// output register. A ring vertex takes two 16-step divisions for the angle
// phases, two 16-step CORDIC runs on the shared rotator, six products through
// one shared multiplier (C_MUL, then C_ACC for each) and the output register.
// The block takes one request at a time; in_stall stays high while it works
// and drops as the result is loaded into the output register, so a new
// request is only taken once the last one is finished.
// The result sits in an output register; while out_stall is high it holds and
// the block waits before finishing the next transaction.
// Reset sets radius 1.0, 16 latitude and 32 longitude segments and the top
// pole. An APB write to the radius or a count register restarts the mesh too.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic signed [31:0] coord_a,
    output logic signed [31:0] coord_b,
    output logic signed [31:0] coord_c,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [15:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last
);
    import usm_pkg::*;

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = 2 * SEG_W + 1;
    localparam int PROD_W = 42;

    typedef enum logic [2:0] {
        ST_TOP, ST_RING, ST_BOTTOM, ST_TOPFAN, ST_BODY_A, ST_BODY_B, ST_BOTFAN
    } stage_t;

    typedef enum logic [2:0] {
        C_IDLE, C_DIV_LON, C_DIV_LAT, C_COR_LAT, C_COR_LON, C_MUL, C_ACC, C_OUT
    } ctl_t;

    ctl_t                      ctl_reg;
    stage_t                    stage_reg;
    logic [23:0]               radius_reg;
    logic [SEG_W-1:0]          lat_cnt_reg;
    logic [SEG_W-1:0]          lon_cnt_reg;
    logic [SEG_W-1:0]          lat_reg;
    logic [SEG_W-1:0]          lon_reg;
    logic [IDX_W-1:0]          base_reg;
    logic [SEG_W-1:0]          lat_w_reg;
    logic [SEG_W-1:0]          lon_w_reg;
    logic                      div_start_reg;
    logic                      cor_start_reg;
    logic [PHASE_W-1:0]        lon_ph_reg;
    logic [PHASE_W-1:0]        lat_ph_reg;
    logic signed [15:0]        cp_reg;
    logic signed [15:0]        sp_reg;
    logic signed [15:0]        ct_reg;
    logic signed [15:0]        st_reg;
    logic signed [25:0]        rr_reg;
    logic [2:0]                k_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // Result staging, then the output register
    logic                      stg_kind;
    logic signed [31:0]        stg_a;
    logic signed [31:0]        stg_b;
    logic signed [31:0]        stg_c;
    logic signed [15:0]        stg_nx;
    logic signed [15:0]        stg_ny;
    logic signed [15:0]        stg_nz;
    logic [15:0]               stg_u;
    logic [16:0]               stg_v;
    logic                      stg_last;
    logic                      out_valid_reg;

    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;
    logic [SEG_W-1:0]          cfg_seg;
    logic                      accept;
    stage_t                    eff_stage;
    logic [SEG_W-1:0]          eff_lat;
    logic [SEG_W-1:0]          eff_lon;
    logic [SEG_W:0]            lon_inc;
    logic                      lon_wrap;
    logic [SEG_W-1:0]          lon_nxt;
    logic [SEG_W:0]            lat_inc;
    logic [IDX_W-1:0]          idx_lon;
    logic [IDX_W-1:0]          idx_nxt;
    logic [IDX_W-1:0]          idx_lon_lo;
    logic [IDX_W-1:0]          idx_nxt_lo;
    logic [IDX_W-1:0]          base_lo;
    logic                      div_done;
    logic [PHASE_W-1:0]        div_quot;
    logic                      cor_done;
    logic signed [15:0]        cor_cos;
    logic signed [15:0]        cor_sin;
    logic signed [25:0]        mul_a;
    logic signed [15:0]        mul_b;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [15:0]        rnd_clamped;

    function automatic logic [SEG_W-1:0] clamp_seg(input logic [8:0] v);
        if (int'(v) < 3) begin
            return SEG_W'(3);
        end
        if (int'(v) > MAX_SEGMENTS) begin
            return SEG_W'(MAX_SEGMENTS);
        end
        return SEG_W'(v);
    endfunction

    usm_div #(.W(SEG_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .numer ((ctl_reg == C_DIV_LAT) ? lat_w_reg : lon_w_reg),
        .denom ((ctl_reg == C_DIV_LAT) ? lat_cnt_reg : lon_cnt_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    usm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start_reg),
        .phase ((ctl_reg == C_COR_LAT) ? lat_ph_reg : lon_ph_reg),
        .done  (cor_done),
        .cos_q (cor_cos),
        .sin_q (cor_sin)
    );

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_seg = clamp_seg(pwdata[8:0]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_RADIUS:    prdata = 32'(radius_reg);
            REG_LAT_COUNT: prdata = 32'(lat_cnt_reg);
            REG_LON_COUNT: prdata = 32'(lon_cnt_reg);
            REG_NONE:      prdata = '0;
        endcase
    end

    assign in_stall  = (ctl_reg != C_IDLE);
    assign accept    = in_valid && !in_stall;
    assign eff_stage = restart ? ST_TOP : stage_reg;
    assign eff_lat   = restart ? '0 : lat_reg;
    assign eff_lon   = restart ? '0 : lon_reg;
    assign lon_inc   = {1'b0, eff_lon} + 1'b1;
    assign lon_wrap  = lon_inc >= {1'b0, lon_cnt_reg};
    assign lon_nxt   = lon_wrap ? '0 : lon_inc[SEG_W-1:0];
    assign lat_inc   = {1'b0, eff_lat} + 1'b1;
    assign idx_lon    = base_reg + IDX_W'(eff_lon);
    assign idx_nxt    = base_reg + IDX_W'(lon_nxt);
    assign base_lo    = base_reg + IDX_W'(lon_cnt_reg);
    assign idx_lon_lo = base_lo + IDX_W'(eff_lon);
    assign idx_nxt_lo = base_lo + IDX_W'(lon_nxt);

    // Shared multiplier operand selection over the six products
    always_comb
    begin
        unique case (k_reg)
            3'd0:
            begin
                mul_a = 26'(radius_reg);
                mul_b = sp_reg;
            end
            3'd1:
            begin
                mul_a = rr_reg;
                mul_b = ct_reg;
            end
            3'd2:
            begin
                mul_a = 26'(radius_reg);
                mul_b = cp_reg;
            end
            3'd3:
            begin
                mul_a = rr_reg;
                mul_b = st_reg;
            end
            3'd4:
            begin
                mul_a = 26'(sp_reg);
                mul_b = ct_reg;
            end
            default:
            begin
                mul_a = 26'(sp_reg);
                mul_b = st_reg;
            end
        endcase
    end

    assign rnd = (prod_reg + PROD_W'(16384)) >>> 15;

    always_comb
    begin
        if (rnd > PROD_W'(Q15_MAX))
        begin
            rnd_clamped = 16'(Q15_MAX);
        end
        else if (rnd < -PROD_W'(Q15_MAX))
        begin
            rnd_clamped = -16'(Q15_MAX);
        end
        else
        begin
            rnd_clamped = rnd[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= C_IDLE;
            stage_reg     <= ST_TOP;
            radius_reg    <= 24'd65536;
            lat_cnt_reg   <= clamp_seg(9'd16);
            lon_cnt_reg   <= clamp_seg(9'd32);
            lat_reg       <= '0;
            lon_reg       <= '0;
            base_reg      <= IDX_W'(1);
            lat_w_reg     <= '0;
            lon_w_reg     <= '0;
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            lon_ph_reg    <= '0;
            lat_ph_reg    <= '0;
            cp_reg        <= '0;
            sp_reg        <= '0;
            ct_reg        <= '0;
            st_reg        <= '0;
            rr_reg        <= '0;
            k_reg         <= '0;
            prod_reg      <= '0;
            stg_kind      <= 1'b0;
            stg_a         <= '0;
            stg_b         <= '0;
            stg_c         <= '0;
            stg_nx        <= '0;
            stg_ny        <= '0;
            stg_nz        <= '0;
            stg_u         <= '0;
            stg_v         <= '0;
            stg_last      <= 1'b0;
            out_valid_reg <= 1'b0;
            kind          <= 1'b0;
            coord_a       <= '0;
            coord_b       <= '0;
            coord_c       <= '0;
            normal_x      <= '0;
            normal_y      <= '0;
            normal_z      <= '0;
            tex_u         <= '0;
            tex_v         <= '0;
            last          <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;

            if (ctl_reg == C_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr && cfg_idx != REG_NONE)
            begin
                unique case (cfg_idx)
                    REG_RADIUS:    radius_reg  <= pwdata[23:0];
                    REG_LAT_COUNT: lat_cnt_reg <= cfg_seg;
                    REG_LON_COUNT: lon_cnt_reg <= cfg_seg;
                    REG_NONE:      radius_reg  <= radius_reg;
                endcase
                stage_reg <= ST_TOP;
                lat_reg   <= '0;
                lon_reg   <= '0;
            end

            unique case (ctl_reg)
                C_IDLE:
                begin
                    if (accept)
                    begin
                        stg_kind <= 1'b1;
                        stg_nx   <= '0;
                        stg_ny   <= '0;
                        stg_nz   <= '0;
                        stg_u    <= '0;
                        stg_v    <= '0;
                        stg_last <= 1'b0;
                        ctl_reg  <= C_OUT;
                        unique case (eff_stage)
                            ST_RING:
                            begin
                                stg_kind      <= 1'b0;
                                lat_w_reg     <= eff_lat;
                                lon_w_reg     <= eff_lon;
                                div_start_reg <= 1'b1;
                                ctl_reg       <= C_DIV_LON;
                                lon_reg       <= lon_inc[SEG_W-1:0];
                                if (lon_wrap)
                                begin
                                    lon_reg <= '0;
                                    lat_reg <= lat_inc[SEG_W-1:0];
                                    stage_reg <= (lat_inc >= {1'b0, lat_cnt_reg}) ?
                                                 ST_BOTTOM : ST_RING;
                                end
                                else
                                begin
                                    lat_reg   <= eff_lat;
                                    stage_reg <= ST_RING;
                                end
                            end
                            ST_BOTTOM:
                            begin
                                stg_kind  <= 1'b0;
                                stg_a     <= '0;
                                stg_b     <= -$signed(32'(radius_reg));
                                stg_c     <= '0;
                                stg_ny    <= -16'(Q15_MAX);
                                stg_u     <= 16'h8000;
                                stage_reg <= ST_TOPFAN;
                                lat_reg   <= '0;
                                lon_reg   <= '0;
                            end
                            ST_TOPFAN:
                            begin
                                stg_a   <= '0;
                                stg_b   <= 32'(lon_nxt) + 32'sd1;
                                stg_c   <= 32'(eff_lon) + 32'sd1;
                                lat_reg <= '0;
                                if (lon_wrap)
                                begin
                                    lon_reg   <= '0;
                                    base_reg  <= IDX_W'(1);
                                    stage_reg <= ST_BODY_A;
                                end
                                else
                                begin
                                    lon_reg   <= lon_inc[SEG_W-1:0];
                                    stage_reg <= ST_TOPFAN;
                                end
                            end
                            ST_BODY_A:
                            begin
                                stg_a     <= 32'(idx_lon);
                                stg_b     <= 32'(idx_nxt);
                                stg_c     <= 32'(idx_lon_lo);
                                lat_reg   <= eff_lat;
                                lon_reg   <= eff_lon;
                                stage_reg <= ST_BODY_B;
                            end
                            ST_BODY_B:
                            begin
                                stg_a     <= 32'(idx_nxt);
                                stg_b     <= 32'(idx_nxt_lo);
                                stg_c     <= 32'(idx_lon_lo);
                                stage_reg <= ST_BODY_A;
                                if (lon_wrap)
                                begin
                                    // Next band: the base advances by one ring
                                    lon_reg  <= '0;
                                    base_reg <= base_lo;
                                    if (lat_inc >= {1'b0, lat_cnt_reg} - 2'd2)
                                    begin
                                        lat_reg   <= '0;
                                        stage_reg <= ST_BOTFAN;
                                    end
                                    else
                                    begin
                                        lat_reg <= lat_inc[SEG_W-1:0];
                                    end
                                end
                                else
                                begin
                                    lon_reg <= lon_inc[SEG_W-1:0];
                                    lat_reg <= eff_lat;
                                end
                            end
                            ST_BOTFAN:
                            begin
                                // The base now points at the last ring.
                                stg_a    <= 32'(idx_lon);
                                stg_b    <= 32'(idx_nxt);
                                stg_c    <= 32'(base_lo);
                                stg_last <= lon_wrap;
                                lat_reg  <= '0;
                                if (lon_wrap)
                                begin
                                    lon_reg   <= '0;
                                    stage_reg <= ST_TOP;
                                end
                                else
                                begin
                                    lon_reg   <= lon_inc[SEG_W-1:0];
                                    stage_reg <= ST_BOTFAN;
                                end
                            end
                            default:
                            begin
                                stg_kind  <= 1'b0;
                                stg_a     <= '0;
                                stg_b     <= $signed(32'(radius_reg));
                                stg_c     <= '0;
                                stg_ny    <= 16'(Q15_MAX);
                                stg_u     <= 16'h8000;
                                stg_v     <= 17'h10000;
                                stage_reg <= ST_RING;
                                lat_reg   <= SEG_W'(1);
                                lon_reg   <= '0;
                                base_reg  <= IDX_W'(1);
                            end
                        endcase
                    end
                end
                C_DIV_LON:
                begin
                    if (div_done)
                    begin
                        lon_ph_reg    <= div_quot;
                        stg_u         <= div_quot;
                        div_start_reg <= 1'b1;
                        ctl_reg       <= C_DIV_LAT;
                    end
                end
                C_DIV_LAT:
                begin
                    if (div_done)
                    begin
                        // floor(lat*2^15/T) is half of floor(lat*2^16/T), rounded down.
                        lat_ph_reg    <= {1'b0, div_quot[PHASE_W-1:1]};
                        stg_v         <= 17'h10000 - {1'b0, div_quot};
                        cor_start_reg <= 1'b1;
                        ctl_reg       <= C_COR_LAT;
                    end
                end
                C_COR_LAT:
                begin
                    if (cor_done)
                    begin
                        cp_reg        <= cor_cos;
                        sp_reg        <= cor_sin;
                        stg_ny        <= cor_cos;
                        cor_start_reg <= 1'b1;
                        ctl_reg       <= C_COR_LON;
                    end
                end
                C_COR_LON:
                begin
                    if (cor_done)
                    begin
                        ct_reg  <= cor_cos;
                        st_reg  <= cor_sin;
                        k_reg   <= '0;
                        ctl_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
                    ctl_reg  <= C_ACC;
                end
                C_ACC:
                begin
                    unique case (k_reg)
                        3'd0:    rr_reg <= rnd[25:0];
                        3'd1:    stg_a  <= rnd[31:0];
                        3'd2:    stg_b  <= rnd[31:0];
                        3'd3:    stg_c  <= rnd[31:0];
                        3'd4:    stg_nx <= rnd_clamped;
                        default: stg_nz <= rnd_clamped;
                    endcase
                    k_reg   <= k_reg + 1'b1;
                    ctl_reg <= (k_reg == 3'd5) ? C_OUT : C_MUL;
                end
                C_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        kind          <= stg_kind;
                        coord_a       <= stg_a;
                        coord_b       <= stg_b;
                        coord_c       <= stg_c;
                        normal_x      <= stg_nx;
                        normal_y      <= stg_ny;
                        normal_z      <= stg_nz;
                        tex_u         <= stg_u;
                        tex_v         <= stg_v;
                        last          <= stg_last;
                        ctl_reg       <= C_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/usm_checker.sv =====
// ----------------------------------------------------------------------------
// usm_port_props
// Port-level checks for the UV-sphere mesh generator, bound to the top level.
// ----------------------------------------------------------------------------
module usm_port_props (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               kind,
    input logic signed [31:0] coord_a,
    input logic signed [15:0] normal_x,
    input logic signed [15:0] normal_y,
    input logic signed [15:0] normal_z,
    input logic [15:0]        tex_u,
    input logic [16:0]        tex_v,
    input logic               last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coord_a) && $stable(kind))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while the previous one is still in work");

    a_tri_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> normal_x == 16'sd0 && normal_y == 16'sd0 &&
        normal_z == 16'sd0 && tex_u == 16'd0 && tex_v == 17'd0)
        else $error("triangle carries vertex attributes");

    a_last_tri: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind)
        else $error("last flag on a vertex");

endmodule

bind uv_sphere_mesh_generator usm_port_props u_usm_port_props (.*);

// ===== tb/usm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usm_checker
// Watches the register port and both channels of the UV-sphere mesh generator,
// predicts every mesh element from its own copy of the state and compares.
// ----------------------------------------------------------------------------
module usm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               restart,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               kind,
    input  logic signed [31:0] coord_a,
    input  logic signed [31:0] coord_b,
    input  logic signed [31:0] coord_c,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        tex_u,
    input  logic [16:0]        tex_v,
    input  logic               last,
    input  logic               drain_check,
    output int                 errors,
    output int                 pending,
    output int                 vertex_cnt,
    output int                 triangle_cnt,
    output int                 mesh_cnt
);
    import usm_pkg::*;

    typedef enum logic [2:0] {
        SG_TOP, SG_RING, SG_BOTTOM, SG_TOPFAN, SG_BODY_A, SG_BODY_B, SG_BOTFAN
    } mesh_stage_t;

    typedef struct {
        logic               kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        u;
        logic [16:0]        v;
        logic               last;
    } mesh_elem_t;

    localparam longint ATAN_TURNS [16] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886,
        83443, 41721, 20860
    };

    longint      radius;
    int          lat_segs;
    int          lon_segs;
    mesh_stage_t stage;
    int          lat_ctr;
    int          lon_ctr;
    mesh_elem_t  expected_elems[$];

    function automatic int clamp_segments(input logic [8:0] v);
        if (v < 3) return 3;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic longint q15_round(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint q15_clamp(input longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    // Rotation-mode CORDIC on the low 14 bits, then a quadrant swap.
    function automatic void cos_sin(input logic [15:0] ph, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(ph[13:0]) <<< 16;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end
            else begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        x = q15_clamp(q15_round(x));
        y = q15_clamp(q15_round(y));
        case (ph[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic mesh_elem_t triangle(input longint a, input longint b, input longint c,
                                            input logic fin);
        mesh_elem_t e;
        e = '{kind: 1'b1, a: a[31:0], b: b[31:0], c: c[31:0], nx: '0, ny: '0, nz: '0,
              u: '0, v: '0, last: fin};
        return e;
    endfunction

    function automatic mesh_elem_t next_element(input logic rs);
        mesh_elem_t e;
        longint     nxt, upper, lower, ring, bottom, cp, sp, ct, st, rr;
        logic [15:0] lon_ph, lat_ph;
        longint     tv;
        nxt    = (lon_ctr + 1) % lon_segs;
        bottom = 1 + longint'(lat_segs - 1) * lon_segs;
        if (rs) begin
            stage = SG_TOP; lat_ctr = 0; lon_ctr = 0;
        end
        case (stage)
            SG_RING: begin
                lon_ph = 16'((longint'(lon_ctr) << 16) / lon_segs);
                lat_ph = 16'((longint'(lat_ctr) << 15) / lat_segs);
                tv = 65536 - (longint'(lat_ctr) << 16) / lat_segs;
                cos_sin(lat_ph, cp, sp);
                cos_sin(lon_ph, ct, st);
                rr = q15_round(radius * sp);
                e.kind = 1'b0;
                e.a  = 32'(q15_round(rr * ct));
                e.b  = 32'(q15_round(radius * cp));
                e.c  = 32'(q15_round(rr * st));
                e.nx = 16'(q15_clamp(q15_round(sp * ct)));
                e.ny = 16'(cp);
                e.nz = 16'(q15_clamp(q15_round(sp * st)));
                e.u  = lon_ph;
                e.v  = 17'(tv < 0 ? 0 : tv);
                e.last = 1'b0;
                lon_ctr++;
                if (lon_ctr >= lon_segs) begin
                    lon_ctr = 0;
                    lat_ctr++;
                    if (lat_ctr >= lat_segs) stage = SG_BOTTOM;
                end
            end
            SG_BOTTOM: begin
                e = '{kind: 1'b0, a: '0, b: 32'(-radius), c: '0, nx: '0, ny: -16'sd32767,
                      nz: '0, u: 16'd32768, v: '0, last: 1'b0};
                stage = SG_TOPFAN; lon_ctr = 0; lat_ctr = 0;
            end
            SG_TOPFAN: begin
                e = triangle(0, 1 + nxt, 1 + lon_ctr, 1'b0);
                lon_ctr++;
                if (lon_ctr >= lon_segs) begin
                    lon_ctr = 0; lat_ctr = 0; stage = SG_BODY_A;
                end
            end
            SG_BODY_A, SG_BODY_B: begin
                upper = 1 + longint'(lat_ctr) * lon_segs;
                lower = upper + lon_segs;
                if (stage == SG_BODY_A) begin
                    e = triangle(upper + lon_ctr, upper + nxt, lower + lon_ctr, 1'b0);
                    stage = SG_BODY_B;
                end
                else begin
                    e = triangle(upper + nxt, lower + nxt, lower + lon_ctr, 1'b0);
                    stage = SG_BODY_A;
                    lon_ctr++;
                    if (lon_ctr >= lon_segs) begin
                        lon_ctr = 0;
                        lat_ctr++;
                        if (lat_ctr >= lat_segs - 2) begin
                            lat_ctr = 0; stage = SG_BOTFAN;
                        end
                    end
                end
            end
            SG_BOTFAN: begin
                ring = 1 + longint'(lat_segs - 2) * lon_segs;
                e = triangle(ring + lon_ctr, ring + nxt, bottom, lon_ctr + 1 >= lon_segs);
                lon_ctr++;
                if (lon_ctr >= lon_segs) begin
                    stage = SG_TOP; lon_ctr = 0; lat_ctr = 0;
                end
            end
            default: begin
                e = '{kind: 1'b0, a: '0, b: 32'(radius), c: '0, nx: '0, ny: 16'sd32767,
                      nz: '0, u: 16'd32768, v: 17'd65536, last: 1'b0};
                stage = SG_RING; lat_ctr = 1; lon_ctr = 0;
            end
        endcase
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic compare_field(input string what, input longint got, input longint want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        mesh_elem_t e;
        if (!rst_n) begin
            radius   <= 65536;
            lat_segs <= 16;
            lon_segs <= 32;
            stage    <= SG_TOP;
            lat_ctr  <= 0;
            lon_ctr  <= 0;
            errors       <= 0;
            pending      <= 0;
            vertex_cnt   <= 0;
            triangle_cnt <= 0;
            mesh_cnt     <= 0;
            expected_elems.delete();
        end
        else begin
            // Blocking updates keep the predictor state in step within one edge.
            if (psel && penable && pwrite && pready && reg_idx_t'(paddr[3:2]) != REG_NONE) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_RADIUS:    radius = longint'(pwdata[23:0]);
                    REG_LAT_COUNT: lat_segs = clamp_segments(pwdata[8:0]);
                    REG_LON_COUNT: lon_segs = clamp_segments(pwdata[8:0]);
                    default: ;
                endcase
                stage = SG_TOP; lat_ctr = 0; lon_ctr = 0;
            end
            if (out_valid && !out_stall) begin
                if (expected_elems.size() == 0) begin
                    report_mismatch("unexpected result, kind", kind, -1);
                end
                else begin
                    e = expected_elems.pop_front();
                    compare_field("kind", kind, e.kind);
                    compare_field("coord_a", coord_a, e.a);
                    compare_field("coord_b", coord_b, e.b);
                    compare_field("coord_c", coord_c, e.c);
                    compare_field("normal_x", normal_x, e.nx);
                    compare_field("normal_y", normal_y, e.ny);
                    compare_field("normal_z", normal_z, e.nz);
                    compare_field("tex_u", tex_u, e.u);
                    compare_field("tex_v", tex_v, e.v);
                    compare_field("last", last, e.last);
                    if (e.kind) triangle_cnt++;
                    else vertex_cnt++;
                    if (e.last) mesh_cnt++;
                end
            end
            if (in_valid && !in_stall)
                expected_elems.insert(expected_elems.size(), next_element(restart));
            if (drain_check && expected_elems.size() != 0)
                report_mismatch("results still outstanding", 0, expected_elems.size());
            pending <= expected_elems.size();
        end
    end

endmodule

// ===== tb/tb_uv_sphere_mesh_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_mesh_generator
// Drives mesh requests and register writes into the UV-sphere generator under
// bursty input and a stalling output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_uv_sphere_mesh_generator;
    import usm_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid, in_stall, restart;
    logic               out_valid, out_stall;
    logic               kind, last;
    logic signed [31:0] coord_a, coord_b, coord_c;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [15:0]        tex_u;
    logic [16:0]        tex_v;
    logic               drain_check;
    int                 errors, pending, vertex_cnt, triangle_cnt, mesh_cnt;
    int                 sent_cnt;
    int                 config_cnt;

    uv_sphere_mesh_generator dut (.*);

    usm_checker checker_i (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial begin
        #(40_000_000);
        $display("uv_sphere_mesh_generator: mismatch");
        $finish;
    end

    // Receiver: changes its stall habit now and then, and holds off once for a
    // long stretch while requests keep coming.
    initial begin
        int mode, left, hold;
        bit held_once;
        out_stall = 1'b0;
        held_once = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(posedge clk);
            if (!held_once && sent_cnt >= 200) begin
                held_once = 1'b1;
                hold = 600;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 400);
            end
            left--;
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (mode == 0) out_stall <= 1'b0;
            else if (mode == 1) out_stall <= ($urandom_range(0, 99) < 25);
            else out_stall <= ($urandom_range(0, 99) < 70);
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_cnt++;
    endtask

    // Waits until the generator has returned every expected element. The first
    // edge lets the checker's count take in a transaction accepted just now.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mesh(input logic [31:0] r, input logic [31:0] lat, input logic [31:0] lon);
        wait_drained();
        write_reg(REG_RADIUS, r);
        write_reg(REG_LAT_COUNT, lat);
        write_reg(REG_LON_COUNT, lon);
    endtask

    // Sends n requests in bursts; restart_pct sets how often a request restarts.
    task automatic send_requests(input int n, input int restart_pct);
        int done_cnt, burst, gap;
        bit taken;
        done_cnt = 0;
        while (done_cnt < n) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            while (burst > 0 && done_cnt < n) begin
                in_valid <= 1'b1;
                restart  <= ($urandom_range(0, 99) < restart_pct);
                do begin
                    @(negedge clk);
                    taken = !in_stall;
                    @(posedge clk);
                end while (!taken);
                burst--;
                done_cnt++;
                sent_cnt++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                restart  <= $urandom_range(0, 1);
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int t, l, n;
        logic [31:0] r, lat_w, lon_w;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; restart = 1'b0; drain_check = 1'b0;
        sent_cnt = 0;
        config_cnt = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset mesh start, an explicit restart, then a whole
        // smallest mesh at full radius with clamped segment counts.
        send_requests(3, 0);
        send_requests(1, 100);
        set_mesh(32'hFF_FFFF, 32'd0, 32'd2);
        send_requests(21, 0);

        // Extremes: zero radius and oversized counts, largest mesh, thin meshes.
        set_mesh(32'd0, 32'd511, 32'd3);
        send_requests(60, 3);
        set_mesh(32'd1, 32'd256, 32'd256);
        send_requests(40, 0);
        set_mesh(32'hFF_FFFF, 32'd3, 32'h1FF);
        send_requests(120, 2);
        set_mesh(32'd65536, 32'd256, 32'd3);
        send_requests(40, 0);

        while (sent_cnt < 1150) begin
            t = $urandom_range(3, 8);
            l = $urandom_range(3, 8);
            lat_w = t;
            lon_w = l;
            case ($urandom_range(0, 5))
                0: r = 32'hFF_FFFF;
                1: r = $urandom_range(0, 1);
                2: r = 32'h1_0000;
                default: r = $urandom_range(0, 32'hFF_FFFF);
            endcase
            if ($urandom_range(0, 7) == 0) lat_w = $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) lon_w = $urandom_range(257, 511);
            if (lon_w > 256) l = 256;
            if (lat_w < 3) t = 3;
            n = (l > 8) ? 80 : 2 + 3 * l * (t - 1) + $urandom_range(0, 10);
            set_mesh(r, lat_w, lon_w);
            send_requests(n, 2);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        drain_check <= 1'b1;
        @(posedge clk);
        drain_check <= 1'b0;
        @(posedge clk);
        $display("Sent %0d requests over %0d register writes.", sent_cnt, config_cnt);
        $display("Checked %0d vertices, %0d triangles, %0d complete meshes.",
                 vertex_cnt, triangle_cnt, mesh_cnt);
        if (errors == 0) begin
            $display("uv_sphere_mesh_generator: match");
        end
        else begin
            $display("uv_sphere_mesh_generator: mismatch");
        end
        $finish;
    end

endmodule

// ===== uv_sphere_mesh_generator.f =====
rtl/usm_pkg.sv
rtl/usm_div.sv
rtl/usm_cordic.sv
rtl/uv_sphere_mesh_generator.sv
rtl/usm_checker.sv
tb/usm_checker.sv
tb/tb_uv_sphere_mesh_generator.sv
